// ===== rtl/egc_pkg.sv =====
// Package for the elevator group controller: constants and payload structs.
// No dependencies.
package egc_pkg;
	localparam int CARS_DEF   = 4;
	localparam int FLOORS_DEF = 32;
	localparam int POS_W      = 17;
	localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_CALL = 2'd1;
	localparam logic [1:0] MODE_DEST = 2'd2;

	localparam logic [2:0] REG_ACTIVE = 3'd0;
	localparam logic [2:0] REG_FLOORS = 3'd1;
	localparam logic [2:0] REG_HEIGHT = 3'd2;
	localparam logic [2:0] REG_SPEED  = 3'd3;
	localparam logic [2:0] REG_DWELL  = 3'd4;
	localparam logic [2:0] REG_MAXST  = 3'd5;
	localparam logic [2:0] REG_GROUND = 3'd6;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] floor;
		logic [2:0] car;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       car_index;
		logic [POS_W-1:0] car_height;
		logic [1:0]       direction;
		logic             arrived;
		logic             accepted;
		logic             last;
	} out_item_t;
endpackage

// ===== rtl/elevator_group_controller_top.sv =====
// Elevator group controller top level: sequencer, car state memory, dispatch scan.
// Depends on egc_pkg.
//
// Each car's state (position, stop sets, heading, dwell) is one word of a
// synchronous memory with a registered read; items are handled one at a
// time by a sequencer that visits the cars in turn. A hall call scans every
// active car and then updates the chosen one; a cabin destination updates its
// named car without a scan; a tick does a read-modify-write per car, preceded
// with ground return by a ground-return scan. The per-car memory port and the
// one-car-per-step scan set how long each item takes. After reset a clearing
// pass writes every car entry, during which no item is taken.
module elevator_group_controller_top
	import egc_pkg::*;
#(
	parameter int CARS   = CARS_DEF,
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;
	localparam int FW = FLOORS;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [FW-1:0]    up;
		logic [FW-1:0]    dn;
		logic [FW-1:0]    pk;
		logic [1:0]       hd;
		logic [15:0]      dw;
	} car_t;

	typedef enum logic [9:0] {
		S_CLR   = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_SRD   = 10'b0000000100,
		S_SCMP  = 10'b0000001000,
		S_SDONE = 10'b0000010000,
		S_URD   = 10'b0000100000,
		S_UMOD  = 10'b0001000000,
		S_UWR   = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_GRD   = 10'b1000000000
	} state_t;

	state_t state_q;
	car_t mem [CARS];
	car_t rd_q;
	logic [CW-1:0] raddr;
	logic ren, wen;
	logic [CW-1:0] waddr;
	car_t wdata;

	logic [3:0]  active_q;
	logic [5:0]  floors_q;
	logic [11:0] fh_q, speed_q;
	logic [15:0] dwell_q;
	logic [5:0]  maxst_q;
	logic        ground_q;

	in_item_t  item_q;
	out_item_t res_q;
	logic [CW-1:0] idx_q;
	logic [CW:0]   ncars;
	logic          best_ok_q;
	logic [CW-1:0] best_q;
	logic [POS_W-1:0] bestd_q;
	logic          at_ground_q;
	logic          gr_phase_q;   // tick: scanning for ground-return car

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		if (ren) rd_q <= mem[raddr];
	end

	always_comb begin
		ncars = (active_q == 4'd0) ? (CW+1)'(1) :
			(32'(active_q) > CARS) ? (CW+1)'(CARS) : (CW+1)'(active_q);
	end

	function automatic logic [POS_W-1:0] height_of(input logic [5:0] f,
		input logic [11:0] h);
		logic [17:0] p;
		p = 18'(f) * 18'(h);
		return (p > 18'(POS_MAX)) ? POS_MAX : p[POS_W-1:0];
	endfunction

	function automatic logic [FW-1:0] bit_of(input logic [5:0] f);
		logic [5:0] s;
		s = f - 6'd1;
		return (32'(s) < FW) ? (FW'(1) << s) : '0;
	endfunction

	function automatic logic [6:0] pop(input logic [FW-1:0] v);
		logic [6:0] c;
		c = '0;
		for (int i = 0; i < FW; i++) c = c + 7'(v[i]);
		return c;
	endfunction

	function automatic logic [5:0] low_f(input logic [FW-1:0] s);
		logic [5:0] f;
		f = 6'd1;
		for (int i = FW-1; i >= 0; i--) if (s[i]) f = 6'(i+1);
		return f;
	endfunction

	function automatic logic [5:0] high_f(input logic [FW-1:0] s);
		logic [5:0] f;
		f = 6'd0;
		for (int i = 0; i < FW; i++) if (s[i]) f = 6'(i+1);
		return f;
	endfunction

	logic [5:0] flim;
	logic fok;
	logic [POS_W-1:0] tgt, span;
	logic elig;
	logic full;
	always_comb begin
		flim = (32'(floors_q) > FLOORS) ? 6'(FLOORS) : floors_q;
		fok  = (item_q.floor != 6'd0) && (item_q.floor <= flim);
		tgt  = height_of(gr_phase_q ? 6'd1 : item_q.floor, fh_q);
		span = (rd_q.pos > tgt) ? rd_q.pos - tgt : tgt - rd_q.pos;
		elig = !((rd_q.hd == DIR_UP && rd_q.pos > tgt) ||
			(rd_q.hd == DIR_DOWN && rd_q.pos < tgt));
		full = (pop(rd_q.up) + pop(rd_q.dn)) >= 7'(maxst_q);
	end

	// call or destination applied to the chosen car
	car_t mod_car;
	logic mod_acc;
	always_comb begin
		logic [POS_W-1:0] t;
		mod_car = rd_q;
		mod_acc = 1'b0;
		t = height_of(item_q.floor, fh_q);
		if (fok && !full) begin
			if (item_q.mode == MODE_CALL) mod_acc = 1'b1;
			if (t > rd_q.pos) begin
				mod_car.up = rd_q.up | bit_of(item_q.floor);
				if (item_q.mode == MODE_CALL)
					mod_car.pk = rd_q.pk | bit_of(item_q.floor);
				mod_acc = 1'b1;
			end else if (t < rd_q.pos) begin
				mod_car.dn = rd_q.dn | bit_of(item_q.floor);
				if (item_q.mode == MODE_CALL)
					mod_car.pk = rd_q.pk | bit_of(item_q.floor);
				mod_acc = 1'b1;
			end
		end
	end

	// tick update of one car
	car_t upd;
	logic upd_arr;
	always_comb begin
		logic [1:0] h;
		logic [5:0] f;
		logic [POS_W-1:0] t, d, st;
		logic [15:0] dw;
		upd = rd_q;
		upd_arr = 1'b0;
		st = (speed_q == 12'd0) ? POS_W'(1) : POS_W'(speed_q);
		if (rd_q.up == '0 && rd_q.dn == '0) h = DIR_STOP;
		else if (rd_q.hd == DIR_UP && rd_q.up != '0) h = DIR_UP;
		else if (rd_q.hd == DIR_DOWN && rd_q.dn != '0) h = DIR_DOWN;
		else if (rd_q.up != '0) h = DIR_UP;
		else h = DIR_DOWN;
		upd.hd = h;
		dw = (rd_q.dw != 16'd0) ? rd_q.dw - 16'd1 : 16'd0;
		upd.dw = dw;
		f = (h == DIR_UP) ? low_f(rd_q.up) : high_f(rd_q.dn);
		t = height_of(f, fh_q);
		d = (rd_q.pos > t) ? rd_q.pos - t : t - rd_q.pos;
		if (h != DIR_STOP && dw == 16'd0) begin
			if (d >= st) begin
				upd.pos = (rd_q.pos < t) ? rd_q.pos + st : rd_q.pos - st;
			end else begin
				upd.pos = t;
				if (h == DIR_UP) upd.up = rd_q.up & ~bit_of(f);
				else upd.dn = rd_q.dn & ~bit_of(f);
				upd.pk = rd_q.pk & ~bit_of(f);
				upd.dw = dwell_q;
				upd_arr = 1'b1;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	always_comb begin
		ren = 1'b0; raddr = idx_q; wen = 1'b0; waddr = idx_q; wdata = upd;
		case (state_q)
			S_CLR: begin
				wen = 1'b1;
				wdata = '{pos: height_of(6'd1, fh_q), up: '0, dn: '0, pk: '0,
					hd: DIR_STOP, dw: 16'd0};
			end
			S_SRD, S_URD: ren = 1'b1;
			S_SDONE: begin
				raddr = best_q;
				ren = 1'b1;
			end
			S_GRD: begin
				// ground stop lands before the first tick read
				wen = !at_ground_q && best_ok_q;
				waddr = best_q;
				wdata = rd_q;
				wdata.dn = rd_q.dn | bit_of(6'd1);
			end
			S_UMOD: begin
				if (item_q.mode != MODE_TICK) begin
					wen = 1'b1;
					waddr = best_q;
					wdata = mod_car;
				end
			end
			S_UWR: wen = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; idx_q <= '0;
			active_q <= 4'd4; floors_q <= 6'd32; fh_q <= 12'd300; speed_q <= 12'd50;
			dwell_q <= 16'd10; maxst_q <= 6'd8; ground_q <= 1'b0;
			best_ok_q <= 1'b0; best_q <= '0; bestd_q <= '0; at_ground_q <= 1'b0;
			gr_phase_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE: active_q <= cfg_data[3:0];
					REG_FLOORS: floors_q <= cfg_data[5:0];
					REG_HEIGHT: fh_q <= cfg_data[11:0];
					REG_SPEED:  speed_q <= cfg_data[11:0];
					REG_DWELL:  dwell_q <= cfg_data;
					REG_MAXST:  maxst_q <= cfg_data[5:0];
					REG_GROUND: ground_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_CLR: begin
					idx_q <= idx_q + CW'(1);
					if (32'(idx_q) == CARS-1) begin
						idx_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (in_valid) begin
					item_q <= in_data;
					idx_q <= '0; best_ok_q <= 1'b0; at_ground_q <= 1'b0;
					if (in_data.mode == MODE_TICK) begin
						gr_phase_q <= ground_q;
						state_q <= ground_q ? S_SRD : S_URD;
					end else if (in_data.mode == MODE_CALL) begin
						gr_phase_q <= 1'b0;
						state_q <= S_SRD;
					end else if (in_data.mode == MODE_DEST) begin
						gr_phase_q <= 1'b0;
						best_q <= CW'(in_data.car);
						best_ok_q <= 1'b1;
						if ({1'b0, in_data.car} >= 4'(ncars)) begin
							res_q <= '{car_index: in_data.car, car_height: '0,
								direction: DIR_STOP, arrived: 1'b0, accepted: 1'b0,
								last: 1'b1};
							state_q <= S_OUT;
						end else state_q <= S_SDONE;
					end else begin
						res_q <= '{car_index: '0, car_height: '0, direction: DIR_STOP,
							arrived: 1'b0, accepted: 1'b0, last: 1'b1};
						state_q <= S_OUT;
					end
				end
				S_SRD: state_q <= S_SCMP;
				S_SCMP: begin
					if (rd_q.pos == POS_W'(fh_q)) at_ground_q <= 1'b1;
					if ((elig || ncars == (CW+1)'(1)) && (!best_ok_q || span < bestd_q)) begin
						best_ok_q <= 1'b1; best_q <= idx_q; bestd_q <= span;
					end
					if ((CW+1)'(idx_q) + (CW+1)'(1) >= ncars) begin
						state_q <= S_SDONE;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_SDONE: begin
					// read of the chosen car issued this cycle
					if (gr_phase_q) state_q <= S_GRD;
					else if (!fok && item_q.mode == MODE_CALL || !best_ok_q) begin
						res_q <= '{car_index: '0, car_height: '0, direction: DIR_STOP,
							arrived: 1'b0, accepted: 1'b0, last: 1'b1};
						state_q <= S_OUT;
					end else state_q <= S_UMOD;
					idx_q <= '0;
				end
				S_GRD: begin
					state_q <= S_UMOD;
					gr_phase_q <= 1'b0;
				end
				S_UMOD: begin
					if (item_q.mode == MODE_TICK) begin
						state_q <= S_URD;
					end else begin
						if (item_q.mode == MODE_CALL && (full || !fok))
							res_q <= '{car_index: '0, car_height: '0, direction: DIR_STOP,
								arrived: 1'b0, accepted: 1'b0, last: 1'b1};
						else
							res_q <= '{car_index: 3'(best_q), car_height: rd_q.pos,
								direction: rd_q.hd, arrived: 1'b0, accepted: mod_acc,
								last: 1'b1};
						state_q <= S_OUT;
					end
				end
				S_URD: state_q <= S_UWR;
				S_UWR: begin
					res_q <= '{car_index: 3'(idx_q), car_height: upd.pos,
						direction: upd.hd, arrived: upd_arr, accepted: 1'b0,
						last: ((CW+1)'(idx_q) + (CW+1)'(1) >= ncars)};
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					if (item_q.mode == MODE_TICK && !res_q.last) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_URD;
					end else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
